// ===== hw/rtl/chd_pkg.sv =====
// Shared types and constants for the convex hull deque block.
`timescale 1ns / 1ps
package chd_pkg;

  localparam int unsigned PointW = 32;

  typedef logic [PointW-1:0] point_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  typedef struct packed {
    point_t p;
    logic   fin;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_B,
    S_TST_B,
    S_RD_T,
    S_TST_T,
    S_PUSH_B,
    S_PUSH_T,
    S_SEED,
    S_EMIT_RD,
    S_EMIT,
    S_ERR
  } state_t;

  // Sign of (b-a)x(c-a) is positive.
  function automatic logic left_of(point_t a, point_t b, point_t c);
    logic signed [16:0] bx, by, cx, cy;
    logic signed [34:0] t1, t2;
    bx = $signed({b[15], b[15:0]}) - $signed({a[15], a[15:0]});
    by = $signed({b[31], b[31:16]}) - $signed({a[31], a[31:16]});
    cx = $signed({c[15], c[15:0]}) - $signed({a[15], a[15:0]});
    cy = $signed({c[31], c[31:16]}) - $signed({a[31], a[31:16]});
    t1 = 35'(bx * cy);
    t2 = 35'(cx * by);
    return (t1 - t2) > 35'sd0;
  endfunction

endpackage

// ===== hw/rtl/chd_front.sv =====
// Input stage: accepts vertices and places them in a short command queue.
`timescale 1ns / 1ps
module chd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  chd_pkg::cmd_t         in_cmd,
  output logic                  q_valid,
  input  logic                  q_ready,
  output chd_pkg::cmd_t         q_cmd
);

  chd_pkg::cmd_t mem_r [2];
  logic [1:0] wp_r, rp_r;

  assign in_ready = (wp_r - rp_r) != 2'd2;
  assign q_valid  = wp_r != rp_r;
  assign q_cmd    = mem_r[rp_r[0]];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_r[wp_r[0]] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r <= 2'd0;
      rp_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= wp_r + 2'd1;
      if (q_valid && q_ready) rp_r <= rp_r + 2'd1;
    end
  end

endmodule

// ===== hw/rtl/chd_back.sv =====
// Deque engine: seeds, pops, pushes and emits the closed hull; flags dropped points and too-few errors.
`timescale 1ns / 1ps
module chd_back #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  chd_pkg::cmd_t  q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    hull_x,
  output logic [15:0]    hull_y,
  output logic [6:0]     hull_pos,
  output logic           run_end,
  output logic [1:0]     status
);

  localparam int unsigned Depth = 2 * MAX_POINTS + 1;
  localparam int unsigned AW = $clog2(Depth);

  chd_pkg::point_t store_r [Depth];
  chd_pkg::point_t seed_r [3];
  chd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] bot_r, bot_nxt, top_r, top_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic drop_r, drop_nxt;
  logic fin_r, fin_nxt;
  chd_pkg::point_t p_r, p_nxt;
  chd_pkg::point_t a_r, b_r;
  logic [AW-1:0] ra0, ra1;
  logic we;
  logic [AW-1:0] wa;
  chd_pkg::point_t wd;
  logic [6:0] h_r, h_nxt;
  logic ov_r, ov_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [6:0] op_r, op_nxt;
  logic oe_r, oe_nxt;
  logic [1:0] os_r, os_nxt;
  logic skip_b_r, skip_b_nxt;
  logic lb, lt;
  logic [AW-1:0] span;

  function automatic logic [AW-1:0] up(logic [AW-1:0] i);
    return (i == AW'(Depth - 1)) ? '0 : i + AW'(1);
  endfunction
  function automatic logic [AW-1:0] dn(logic [AW-1:0] i);
    return (i == '0) ? AW'(Depth - 1) : i - AW'(1);
  endfunction

  assign span = (top_r >= bot_r) ? top_r - bot_r : AW'(top_r + AW'(Depth) - bot_r);
  assign lb = chd_pkg::left_of(a_r, b_r, p_r);
  assign lt = lb;

  always_ff @(posedge clk) begin
    if (we) store_r[wa] <= wd;
    a_r <= store_r[ra0];
    b_r <= store_r[ra1];
    if (q_valid && q_ready && cnt_r < 7'd3) seed_r[cnt_r[1:0]] <= q_cmd.p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chd_pkg::S_IDLE;
      bot_r <= '0; top_r <= '0; cnt_r <= '0; drop_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bot_r <= bot_nxt; top_r <= top_nxt; cnt_r <= cnt_nxt; drop_r <= drop_nxt;
      ov_r <= ov_nxt;
    end
    fin_r <= fin_nxt; p_r <= p_nxt; h_r <= h_nxt; skip_b_r <= skip_b_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; op_r <= op_nxt; oe_r <= oe_nxt; os_r <= os_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    bot_nxt = bot_r; top_nxt = top_r; cnt_nxt = cnt_r; drop_nxt = drop_r;
    fin_nxt = fin_r; p_nxt = p_r; h_nxt = h_r; skip_b_nxt = skip_b_r;
    ov_nxt = ov_r; ox_nxt = ox_r; oy_nxt = oy_r; op_nxt = op_r; oe_nxt = oe_r;
    os_nxt = os_r;
    ra0 = bot_r; ra1 = up(bot_r);
    we = 1'b0; wa = bot_r; wd = p_r;
    q_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      chd_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          p_nxt = q_cmd.p;
          fin_nxt = q_cmd.fin;
          if (cnt_r < 7'(MAX_POINTS)) begin
            cnt_nxt = cnt_r + 7'd1;
            if (cnt_r == 7'd2) state_nxt = chd_pkg::S_SEED;
            else if (cnt_r > 7'd2) state_nxt = chd_pkg::S_RD_B;
            else if (q_cmd.fin) state_nxt = chd_pkg::S_ERR;
          end else begin
            drop_nxt = 1'b1;
            if (q_cmd.fin) state_nxt = (cnt_r < 7'd3) ? chd_pkg::S_ERR : chd_pkg::S_EMIT_RD;
          end
          h_nxt = '0;
        end
      end
      chd_pkg::S_SEED: begin
        we = 1'b1; wa = '0; wd = seed_r[2];
        bot_nxt = '0; top_nxt = AW'(3);
        state_nxt = chd_pkg::S_PUSH_T;
        h_nxt = 7'd1;
      end
      chd_pkg::S_RD_B: begin
        ra0 = bot_r; ra1 = up(bot_r);
        skip_b_nxt = 1'b0;
        state_nxt = chd_pkg::S_TST_B;
      end
      chd_pkg::S_TST_B: begin
        if (!skip_b_r) begin
          skip_b_nxt = lb;
          ra0 = dn(top_r); ra1 = top_r;
          state_nxt = chd_pkg::S_RD_T;
        end else begin
          if (span > AW'(1) && !lb) begin
            bot_nxt = up(bot_r);
            ra0 = up(bot_r); ra1 = up(up(bot_r));
          end else begin
            state_nxt = chd_pkg::S_PUSH_B;
          end
        end
      end
      chd_pkg::S_RD_T: begin
        // first-pass top test result is in a_r/b_r
        if (skip_b_r && lt) begin
          state_nxt = fin_r ? chd_pkg::S_EMIT_RD : chd_pkg::S_IDLE;
          h_nxt = '0;
        end else begin
          ra0 = bot_r; ra1 = up(bot_r);
          skip_b_nxt = 1'b1;
          state_nxt = chd_pkg::S_TST_B;
        end
      end
      chd_pkg::S_PUSH_B: begin
        we = 1'b1; wa = dn(bot_r); wd = p_r;
        bot_nxt = dn(bot_r);
        ra0 = dn(top_r); ra1 = top_r;
        state_nxt = chd_pkg::S_TST_T;
      end
      chd_pkg::S_TST_T: begin
        if (span > AW'(1) && !lt) begin
          top_nxt = dn(top_r);
          ra0 = dn(dn(top_r)); ra1 = dn(top_r);
        end else begin
          h_nxt = '0;
          state_nxt = chd_pkg::S_PUSH_T;
        end
      end
      chd_pkg::S_PUSH_T: begin
        // also finishes seeding: h_r steps through entries 1..3
        if (h_r == 7'd0) begin
          we = 1'b1; wa = up(top_r); wd = p_r;
          top_nxt = up(top_r);
          state_nxt = fin_r ? chd_pkg::S_EMIT_RD : chd_pkg::S_IDLE;
        end else begin
          we = 1'b1;
          wa = AW'(h_r);
          if (h_r == 7'd3) wd = seed_r[2];
          else if (chd_pkg::left_of(seed_r[0], seed_r[1], seed_r[2]))
            wd = (h_r == 7'd1) ? seed_r[0] : seed_r[1];
          else
            wd = (h_r == 7'd1) ? seed_r[1] : seed_r[0];
          h_nxt = h_r + 7'd1;
          if (h_r == 7'd3) begin
            h_nxt = '0;
            state_nxt = fin_r ? chd_pkg::S_EMIT_RD : chd_pkg::S_IDLE;
          end
        end
      end
      chd_pkg::S_EMIT_RD: begin
        ra0 = bot_r;
        state_nxt = chd_pkg::S_EMIT;
      end
      chd_pkg::S_EMIT: begin
        ra0 = bot_r;
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ox_nxt = a_r[15:0]; oy_nxt = a_r[31:16];
          op_nxt = h_r;
          os_nxt = drop_r ? chd_pkg::ST_DROPPED : chd_pkg::ST_OK;
          oe_nxt = (bot_r == top_r);
          h_nxt = h_r + 7'd1;
          if (bot_r == top_r) begin
            bot_nxt = '0; top_nxt = '0; cnt_nxt = '0; drop_nxt = 1'b0;
            state_nxt = chd_pkg::S_IDLE;
          end else begin
            bot_nxt = up(bot_r);
            state_nxt = chd_pkg::S_EMIT_RD;
          end
        end
      end
      chd_pkg::S_ERR: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ox_nxt = '0; oy_nxt = '0; op_nxt = '0; oe_nxt = 1'b1;
          os_nxt = chd_pkg::ST_TOO_FEW;
          bot_nxt = '0; top_nxt = '0; cnt_nxt = '0; drop_nxt = 1'b0;
          state_nxt = chd_pkg::S_IDLE;
        end
      end
      default: state_nxt = chd_pkg::S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign hull_x = ox_r;
  assign hull_y = oy_r;
  assign hull_pos = op_r;
  assign run_end = oe_r;
  assign status = os_r;

endmodule

// ===== hw/rtl/convex_hull_deque.sv =====
// Top level of the deque convex hull block.
//   channel | dir | fields
//   in_     | in  | tdata {py, px}, tlast final_point
//   out_    | out | tdata {hull_pos, hull_y, hull_x}, tuser status, tlast run_end
// A vertex inside the hull passes the bottom and top tests and is discarded; an outside vertex also pops and pushes.
// Emission reads each hull entry through store read port ra0, in states S_EMIT_RD and S_EMIT.
// Reset clears pointers and counts; the store needs no clearing.
// A two-entry queue lets the input keep arriving while the engine works or stalls.
`timescale 1ns / 1ps
module convex_hull_deque #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // px, py
  input  logic        in_tlast,   // final_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // hull_x, hull_y, hull_pos, zero pad
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast   // run_end
);

  chd_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [15:0] hx, hy;
  logic [6:0] hp;

  assign in_cmd = {in_tdata, in_tlast};

  chd_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  chd_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .hull_x(hx), .hull_y(hy), .hull_pos(hp), .run_end(out_tlast), .status(out_tuser)
  );

  assign out_tdata = {1'b0, hp, hy, hx};

endmodule

// ===== hw/rtl/chd_checker.sv =====
// Port-level checker for the convex hull deque block.
`timescale 1ns / 1ps
module chd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped under stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= chd_pkg::ST_DROPPED)
    else $error("bad status");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == chd_pkg::ST_TOO_FEW |-> out_tlast && out_tdata == 40'd0)
    else $error("bad error result");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid && out_tready
      |-> out_tdata[38:32] == $past(out_tdata[38:32]) + 7'd1)
    else $error("position skipped");

endmodule

bind convex_hull_deque chd_checker u_chd_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);
